// ===== hw/rtl/bpc_pkg.sv =====
package bpc_pkg;

    // Field widths
    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int TEMP_W  = 19;
    localparam int PRES_W  = 20;
    localparam int IDX_W   = 3;

    // Internal datapath widths
    localparam int T_W     = 18;   // TEMP - 2000
    localparam int OS_W    = 36;   // first-order OFF and SENS
    localparam int SQ_W    = 35;   // squared temperature terms
    localparam int CORR_W  = 39;   // OFF2 and SENS2
    localparam int FIN_W   = 40;   // corrected OFF and SENS

    // Temperature thresholds in hundredths of a degree
    localparam int TEMP_REF  = 2000;
    localparam int TEMP_VLOW = -1500;
    localparam int VLOW_SPAN = TEMP_REF - TEMP_VLOW;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } t_reg_idx;

endpackage

// ===== hw/rtl/bpc_corr.sv =====
module bpc_corr import bpc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [T_W-1:0]    i_t,
    input  logic signed [OS_W-1:0]   i_off,
    input  logic signed [OS_W-1:0]   i_sens,
    output logic                     o_valid,
    output logic signed [FIN_W-1:0]  o_off,
    output logic signed [FIN_W-1:0]  o_sens
);

    logic [2:0]               r_valid;

    logic [SQ_W-1:0]          r_sq;
    logic [SQ_W-1:0]          r_sq2;
    logic                     r_low;
    logic                     r_vlow;
    logic signed [OS_W-1:0]   r_off_a;
    logic signed [OS_W-1:0]   r_sens_a;

    logic [CORR_W-1:0]        r_off2;
    logic [CORR_W-1:0]        r_sens2;
    logic signed [OS_W-1:0]   r_off_b;
    logic signed [OS_W-1:0]   r_sens_b;

    logic signed [FIN_W-1:0]  r_off_f;
    logic signed [FIN_W-1:0]  r_sens_f;

    logic signed [T_W:0]      w_u;
    logic signed [2*T_W-1:0]  w_sq;
    logic signed [2*T_W+1:0]  w_sq2;
    logic [SQ_W+2:0]          w_sq5;
    logic [SQ_W+2:0]          w_sq2x7;
    logic [SQ_W+3:0]          w_sq2x11;
    logic [CORR_W-1:0]        w_off2;
    logic [CORR_W-1:0]        w_sens2;

    // Square the distances below the two thresholds
    assign w_u   = $signed({i_t[T_W-1], i_t}) + $signed((T_W+1)'(VLOW_SPAN));
    assign w_sq  = i_t * i_t;
    assign w_sq2 = w_u * w_u;

    // Scale the squares by shifts, adds and a subtract
    assign w_sq5    = (SQ_W+3)'({r_sq, 2'b00}) + (SQ_W+3)'(r_sq);
    assign w_sq2x7  = (SQ_W+3)'({r_sq2, 3'b000}) - (SQ_W+3)'(r_sq2);
    assign w_sq2x11 = (SQ_W+4)'({r_sq2, 3'b000}) + (SQ_W+4)'({r_sq2, 1'b0})
                    + (SQ_W+4)'(r_sq2);

    assign w_off2  = r_low ? (CORR_W'(w_sq5 >> 1)
                             + (r_vlow ? CORR_W'(w_sq2x7) : '0)) : '0;
    assign w_sens2 = r_low ? (CORR_W'(w_sq5 >> 2)
                             + (r_vlow ? CORR_W'(w_sq2x11 >> 1) : '0)) : '0;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    // Squares, corrections, then subtract
    always_ff @(posedge i_clk) begin
        r_sq     <= w_sq[SQ_W-1:0];
        r_sq2    <= w_sq2[SQ_W-1:0];
        r_low    <= i_t[T_W-1];
        r_vlow   <= (i_t < -$signed((T_W)'(VLOW_SPAN)));
        r_off_a  <= i_off;
        r_sens_a <= i_sens;

        r_off2   <= w_off2;
        r_sens2  <= w_sens2;
        r_off_b  <= r_off_a;
        r_sens_b <= r_sens_a;

        r_off_f  <= $signed({{(FIN_W-OS_W){r_off_b[OS_W-1]}}, r_off_b})
                  - $signed({1'b0, r_off2});
        r_sens_f <= $signed({{(FIN_W-OS_W){r_sens_b[OS_W-1]}}, r_sens_b})
                  - $signed({1'b0, r_sens2});
    end

    assign o_valid = r_valid[2];
    assign o_off   = r_off_f;
    assign o_sens  = r_sens_f;

endmodule

// ===== hw/rtl/bpc_pres.sv =====
module bpc_pres import bpc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [RAW_W-1:0]         i_d1,
    input  logic signed [FIN_W-1:0]  i_off,
    input  logic signed [FIN_W-1:0]  i_sens,
    output logic                     o_valid,
    output logic [PRES_W-1:0]        o_pressure,
    output logic                     o_saturated
);

    localparam int LO_W   = FIN_W / 2;
    localparam int HI_W   = FIN_W - LO_W;
    localparam int PLO_W  = RAW_W + LO_W;
    localparam int PHI_W  = RAW_W + 1 + HI_W;
    localparam int PROD_W = PHI_W + LO_W;
    localparam int X_W    = PROD_W - 21;
    localparam int Y_W    = X_W + 1;
    localparam int P_W    = Y_W - 15;

    logic [3:0]               r_valid;

    logic [PLO_W-1:0]         r_plo;
    logic signed [PHI_W-1:0]  r_phi;
    logic signed [FIN_W-1:0]  r_off7;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [FIN_W-1:0]  r_off8;

    logic signed [Y_W-1:0]    r_y;

    logic [PRES_W-1:0]        r_pressure;
    logic                     r_sat;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_x;
    logic signed [Y_W-1:0]    w_y;
    logic [P_W-1:0]           w_p;
    logic                     w_neg;
    logic                     w_over;

    // Combine partial products, scale, remove offset
    assign w_prod = ($signed({{LO_W{r_phi[PHI_W-1]}}, r_phi}) <<< LO_W)
                  + $signed({{(PROD_W-PLO_W){1'b0}}, r_plo});
    assign w_x    = r_prod >>> 21;
    assign w_y    = $signed(w_x[Y_W-1:0])
                  - $signed({{(Y_W-FIN_W){r_off8[FIN_W-1]}}, r_off8});

    // Saturate to the output range
    assign w_p    = r_y[Y_W-1:15];
    assign w_neg  = r_y[Y_W-1];
    assign w_over = !w_neg && (|w_p[P_W-1:PRES_W]);

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_plo  <= i_d1 * i_sens[LO_W-1:0];
        r_phi  <= $signed({1'b0, i_d1}) * $signed(i_sens[FIN_W-1:LO_W]);
        r_off7 <= i_off;

        r_prod <= w_prod;
        r_off8 <= r_off7;

        r_y    <= w_y;

        if (w_neg) begin
            r_pressure <= '0;
        end else if (w_over) begin
            r_pressure <= '1;
        end else begin
            r_pressure <= w_p[PRES_W-1:0];
        end
        r_sat <= w_neg || w_over;
    end

    assign o_valid     = r_valid[3];
    assign o_pressure  = r_pressure;
    assign o_saturated = r_sat;

endmodule

// ===== hw/rtl/baro_pressure_temp_compensation_top.sv =====
// Barometric pressure compensation, second-order scheme.
//
// Input: raise start with one raw temperature word and one averaged raw
// pressure word; the item is taken at a clock edge where start is high and
// busy is low. busy is high only during reset and the cycle after it, so an
// item can be offered on every cycle.
// Output: when an item leaves the last stage, o_done is high for exactly one
// cycle with the temperature in hundredths of a degree, the pressure in
// pascals and the clip flag. The receiver cannot stall; results leave at the
// rate items enter, one per cycle.
// The pipeline has ten register stages: raw difference, three
// coefficient products, first-order terms, squares, corrections, subtract,
// two partial products of the pressure multiply, recombine, offset removal
// and clipping.
// Configuration: six calibration words written through the cfg channel,
// index 0 to 5; o_cfg_ready is always high and other indexes are dropped.
// Write them only while no item is in flight.
// Reset clears the calibration words to zero and empties the pipeline.
module baro_pressure_temp_compensation_top import bpc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [RAW_W-1:0]          i_raw_temperature,
    input  logic [RAW_W-1:0]          i_raw_pressure,
    output logic                      o_done,
    output logic signed [TEMP_W-1:0]  o_temperature_centideg,
    output logic [PRES_W-1:0]         o_pressure_pascal,
    output logic                      o_pressure_saturated,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [IDX_W-1:0]          i_cfg_index,
    input  logic [COEF_W-1:0]         i_cfg_data
);

    localparam int DT_W   = RAW_W + 1;
    localparam int PR_W   = DT_W + COEF_W + 1;
    localparam int TDLY_N = 7;
    localparam int DDLY_N = 3;

    logic                       r_busy;
    logic [COEF_W-1:0]          r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    logic                       r_v1, r_v2, r_v3;
    logic signed [DT_W-1:0]     r_s1_dt;
    logic [RAW_W-1:0]           r_s1_d1;
    logic signed [PR_W-1:0]     r_s2_tprod;
    logic signed [PR_W-1:0]     r_s2_oprod;
    logic signed [PR_W-1:0]     r_s2_sprod;
    logic [RAW_W-1:0]           r_s2_d1;
    logic signed [T_W-1:0]      r_s3_t;
    logic signed [TEMP_W-1:0]   r_s3_temp;
    logic signed [OS_W-1:0]     r_s3_off;
    logic signed [OS_W-1:0]     r_s3_sens;
    logic [RAW_W-1:0]           r_s3_d1;

    logic signed [TEMP_W-1:0]   r_temp_dly [TDLY_N];
    logic [RAW_W-1:0]           r_d1_dly [DDLY_N];

    logic                       w_accept;
    logic signed [DT_W-1:0]     w_dt;
    logic signed [PR_W-1:0]     w_tprod;
    logic signed [PR_W-1:0]     w_oprod;
    logic signed [PR_W-1:0]     w_sprod;
    logic signed [PR_W-1:0]     w_tsh;
    logic signed [PR_W-1:0]     w_osh;
    logic signed [PR_W-1:0]     w_ssh;

    logic                       w_corr_valid;
    logic signed [FIN_W-1:0]    w_off_f;
    logic signed [FIN_W-1:0]    w_sens_f;

    assign w_accept    = start && !busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    // Hold busy through reset and the cycle after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // Write calibration words; drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_C1: r_c1 <= i_cfg_data;
                REG_C2: r_c2 <= i_cfg_data;
                REG_C3: r_c3 <= i_cfg_data;
                REG_C4: r_c4 <= i_cfg_data;
                REG_C5: r_c5 <= i_cfg_data;
                REG_C6: r_c6 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front stages: difference, products, first-order terms
    assign w_dt    = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, r_c5, 8'h00});
    assign w_tprod = r_s1_dt * $signed({1'b0, r_c6});
    assign w_oprod = r_s1_dt * $signed({1'b0, r_c4});
    assign w_sprod = r_s1_dt * $signed({1'b0, r_c3});
    assign w_tsh   = r_s2_tprod >>> 23;
    assign w_osh   = r_s2_oprod >>> 7;
    assign w_ssh   = r_s2_sprod >>> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_dt    <= w_dt;
        r_s1_d1    <= i_raw_pressure;

        r_s2_tprod <= w_tprod;
        r_s2_oprod <= w_oprod;
        r_s2_sprod <= w_sprod;
        r_s2_d1    <= r_s1_d1;

        r_s3_t     <= w_tsh[T_W-1:0];
        r_s3_temp  <= $signed({w_tsh[T_W-1], w_tsh[T_W-1:0]})
                    + $signed(TEMP_W'(TEMP_REF));
        r_s3_off   <= $signed({{(OS_W-COEF_W-16){1'b0}}, r_c2, 16'h0000})
                    + $signed(w_osh[OS_W-1:0]);
        r_s3_sens  <= $signed({{(OS_W-COEF_W-15){1'b0}}, r_c1, 15'h0000})
                    + $signed(w_ssh[OS_W-1:0]);
        r_s3_d1    <= r_s2_d1;
    end

    // Carry temperature and raw pressure alongside the later stages
    always_ff @(posedge i_clk) begin
        r_temp_dly[0] <= r_s3_temp;
        for (int i = 1; i < TDLY_N; i++) begin
            r_temp_dly[i] <= r_temp_dly[i-1];
        end
        r_d1_dly[0] <= r_s3_d1;
        for (int i = 1; i < DDLY_N; i++) begin
            r_d1_dly[i] <= r_d1_dly[i-1];
        end
    end

    bpc_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_t     (r_s3_t),
        .i_off   (r_s3_off),
        .i_sens  (r_s3_sens),
        .o_valid (w_corr_valid),
        .o_off   (w_off_f),
        .o_sens  (w_sens_f)
    );

    bpc_pres u_pres (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_corr_valid),
        .i_d1        (r_d1_dly[DDLY_N-1]),
        .i_off       (w_off_f),
        .i_sens      (w_sens_f),
        .o_valid     (o_done),
        .o_pressure  (o_pressure_pascal),
        .o_saturated (o_pressure_saturated)
    );

    assign o_temperature_centideg = r_temp_dly[TDLY_N-1];

endmodule

// ===== verif/baro_pressure_temp_compensation_top_tb.sv =====
module baro_pressure_temp_compensation_top_tb;
    import bpc_pkg::*;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_cd;
        logic [PRES_W-1:0]        pres_pa;
        logic                     clipped;
    } t_reading;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [COEF_W-1:0] data;
    } t_reg_write;

    typedef logic [COEF_W-1:0] t_calib_set [6];

    // Indexes past the last calibration word; writes there must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(REG_C6 + 1);
    localparam logic [IDX_W-1:0] REG_SPARE_HI = '1;

    localparam longint RAW_MAX  = (64'd1 << RAW_W) - 1;
    localparam longint PRES_MAX = (64'd1 << PRES_W) - 1;
    localparam int     SETTLE_CYCLES = 20;

    // Typical factory calibration of this sensor family
    localparam t_calib_set DATASHEET_CAL = '{40127, 36924, 23317, 23282, 33464, 28312};

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [RAW_W-1:0]         i_raw_temperature = '0;
    logic [RAW_W-1:0]         i_raw_pressure = '0;
    logic                     o_done;
    logic signed [TEMP_W-1:0] o_temperature_centideg;
    logic [PRES_W-1:0]        o_pressure_pascal;
    logic                     o_pressure_saturated;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [IDX_W-1:0]         i_cfg_index = '0;
    logic [COEF_W-1:0]        i_cfg_data = '0;

    longint   calib [6];
    t_reading expected_readings [$];
    t_reg_write cfg_queue [$];
    int       sender_idle_pct = 0;
    int       n_sent = 0;
    int       n_checked = 0;
    int       n_errors = 0;
    int       n_cold = 0;
    int       n_very_cold = 0;
    int       n_clipped = 0;

    baro_pressure_temp_compensation_top uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .start                  (start),
        .busy                   (busy),
        .i_raw_temperature      (i_raw_temperature),
        .i_raw_pressure         (i_raw_pressure),
        .o_done                 (o_done),
        .o_temperature_centideg (o_temperature_centideg),
        .o_pressure_pascal      (o_pressure_pascal),
        .o_pressure_saturated   (o_pressure_saturated),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Second-order compensation of one raw temperature and pressure pair
    function automatic t_reading compensate(input logic [RAW_W-1:0] d2,
                                            input logic [RAW_W-1:0] d1);
        longint dt, temp, off, sens, off2, sens2, t, u, p;
        t_reading r;
        dt   = longint'(d2) - calib[REG_C5] * 256;
        temp = TEMP_REF + ((dt * calib[REG_C6]) >>> 23);
        off  = calib[REG_C2] * 65536 + ((calib[REG_C4] * dt) >>> 7);
        sens = calib[REG_C1] * 32768 + ((calib[REG_C3] * dt) >>> 8);
        off2  = 0;
        sens2 = 0;
        if (temp < TEMP_REF) begin
            t = temp - TEMP_REF;
            off2  = 5 * t * t / 2;
            sens2 = 5 * t * t / 4;
            if (temp < TEMP_VLOW) begin
                u = temp - TEMP_VLOW;
                off2  += 7 * u * u;
                sens2 += 11 * u * u / 2;
            end
        end
        off  -= off2;
        sens -= sens2;
        p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
        r.clipped = 1'b0;
        if (p < 0) begin
            p = 0;
            r.clipped = 1'b1;
        end else if (p > PRES_MAX) begin
            p = PRES_MAX;
            r.clipped = 1'b1;
        end
        r.temp_cd = temp[TEMP_W-1:0];
        r.pres_pa = p[PRES_W-1:0];
        return r;
    endfunction

    task automatic report_field(input string name, input longint want, input longint got);
        n_errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    endtask

    // Check results, track calibration writes and predict each accepted item
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) calib[k] = 0;
            expected_readings.delete();
        end else begin
            if (o_done) begin
                if (expected_readings.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, temp %0d pressure %0d", $time,
                             o_temperature_centideg, o_pressure_pascal);
                end else begin
                    want = expected_readings.pop_front();
                    n_checked++;
                    if (o_temperature_centideg !== want.temp_cd)
                        report_field("temperature", want.temp_cd, o_temperature_centideg);
                    if (o_pressure_pascal !== want.pres_pa)
                        report_field("pressure", want.pres_pa, o_pressure_pascal);
                    if (o_pressure_saturated !== want.clipped)
                        report_field("clip flag", want.clipped, o_pressure_saturated);
                end
            end
            if (i_cfg_valid && o_cfg_ready && i_cfg_index <= REG_C6)
                calib[i_cfg_index] = longint'(i_cfg_data);
            if (start && !busy) begin
                want = compensate(i_raw_temperature, i_raw_pressure);
                expected_readings.push_back(want);
                if (want.temp_cd < TEMP_REF) n_cold++;
                if (want.temp_cd < TEMP_VLOW) n_very_cold++;
                if (want.clipped) n_clipped++;
            end
        end
    end

    // Offer one item, hold it until taken, then idle at random
    task automatic send_item(input logic [RAW_W-1:0] d2, input logic [RAW_W-1:0] d1);
        int gap;
        start <= 1'b1;
        i_raw_temperature <= d2;
        i_raw_pressure <= d1;
        do @(posedge i_clk); while (busy);
        n_sent++;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            i_raw_temperature <= RAW_W'($urandom);
            i_raw_pressure <= RAW_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop start and hold until every expected result has come back
    task automatic wait_idle();
        start <= 1'b0;
        do @(negedge i_clk); while (expected_readings.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic issue_writes();
        t_reg_write w;
        while (cfg_queue.size() > 0) begin
            w = cfg_queue.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= w.idx;
            i_cfg_data <= w.data;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_calib(input t_calib_set cs);
        for (int k = 0; k < 6; k++)
            cfg_queue.push_back('{idx: t_reg_idx'(k), data: cs[k]});
        issue_writes();
    endtask

    function automatic t_calib_set pick_calib();
        t_calib_set cs;
        int mode;
        mode = $urandom_range(99);
        for (int k = 0; k < 6; k++) begin
            if (mode < 60)
                cs[k] = DATASHEET_CAL[k] + COEF_W'($urandom_range(8191)) - 16'd4096;
            else if (mode < 85)
                cs[k] = COEF_W'($urandom);
            else if (mode < 92)
                cs[k] = '1;
            else
                cs[k] = $urandom_range(1) ? '1 : '0;
        end
        return cs;
    endfunction

    // Registers still at their reset value of zero
    task automatic test_zero_calibration();
        send_item('0, '0);
        send_item('1, '1);
        send_item('1, '0);
        send_item('0, '1);
        wait_idle();
    endtask

    task automatic test_datasheet_point();
        load_calib(DATASHEET_CAL);
        send_item(24'd8569150, 24'd9085466);
        send_item(24'd8400000, 24'd9085466);
        send_item('0, 24'd9085466);
        send_item('1, 24'd9085466);
        send_item(24'd8569150, '0);
        send_item(24'd8569150, '1);
        wait_idle();
    endtask

    // Slope of one hundredth per 256 counts puts both thresholds on exact codes
    task automatic test_temperature_thresholds();
        t_calib_set cs;
        cs = DATASHEET_CAL;
        cs[REG_C5] = 16'd32768;
        cs[REG_C6] = 16'd32768;
        load_calib(cs);
        send_item(24'd8388608 + 24'd255, 24'd9085466);
        send_item(24'd8388608, 24'd9085466);
        send_item(24'd8388607, 24'd9085466);
        send_item(24'd7492608, 24'd9085466);
        send_item(24'd7492607, 24'd9085466);
        wait_idle();
    endtask

    task automatic test_pressure_clipping();
        // Large sensitivity with a hot reading runs past the top of the range
        load_calib('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF});
        send_item('1, '1);
        send_item('1, '0);
        wait_idle();
        // Offset alone pulls the pressure below zero
        load_calib('{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_item(24'd123456, '1);
        wait_idle();
        // Every word at its maximum: deepest cold and hottest reading
        load_calib('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_item('0, '1);
        send_item('1, '1);
        wait_idle();
    endtask

    task automatic test_unused_register_index();
        load_calib(DATASHEET_CAL);
        cfg_queue.push_back('{idx: REG_SPARE_LO, data: 16'hA5C3});
        cfg_queue.push_back('{idx: REG_SPARE_HI, data: 16'h5A3C});
        cfg_queue.push_back('{idx: REG_C6, data: 16'd30000});
        issue_writes();
        send_item(24'd8569150, 24'd9085466);
        send_item(24'd7000000, 24'd8000000);
        wait_idle();
    endtask

    // Mostly plausible readings around the reference, with some raw noise
    task automatic run_random_phase(input int idle_pct, input int n_items);
        t_calib_set cs;
        longint ref_level, v;
        logic [RAW_W-1:0] d2, d1;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < n_items; n++) begin
            if (n % 50 == 0) begin
                wait_idle();
                cs = pick_calib();
                load_calib(cs);
                ref_level = longint'(cs[REG_C5]) * 256;
            end
            if ($urandom_range(99) < 25) begin
                d2 = RAW_W'($urandom);
            end else begin
                v = ref_level + longint'($urandom_range(3000000)) - 2000000;
                if (v < 0) v = 0;
                else if (v > RAW_MAX) v = RAW_MAX;
                d2 = v[RAW_W-1:0];
            end
            if ($urandom_range(99) < 25) d1 = RAW_W'($urandom);
            else d1 = 24'd6000000 + RAW_W'($urandom_range(6000000));
            send_item(d2, d1);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_calibration();
        test_datasheet_point();
        test_temperature_thresholds();
        test_pressure_clipping();
        test_unused_register_index();
        run_random_phase(0, 466);
        run_random_phase(77, 467);
        run_random_phase(28, 467);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Checked %0d readings from %0d items over several calibration sets",
                 n_checked, n_sent);
        $display("%0d below 20 C, %0d below -15 C, %0d with clipped pressure",
                 n_cold, n_very_cold, n_clipped);
        if (n_errors == 0 && expected_readings.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_corr.sv
hw/rtl/bpc_pres.sv
hw/rtl/baro_pressure_temp_compensation_top.sv
verif/baro_pressure_temp_compensation_top_tb.sv
